// ===== sv/kaes_pkg.sv =====
`default_nettype none

package kaes_pkg;

    // Input word layout of the button masks
    localparam int unsigned BIT_RIGHT = 0;
    localparam int unsigned BIT_LEFT  = 1;
    localparam int unsigned BIT_UP    = 2;
    localparam int unsigned BIT_DOWN  = 3;
    localparam int unsigned BIT_A     = 4;
    localparam int unsigned BIT_B     = 5;
    localparam int unsigned BIT_START = 7;
    localparam int unsigned DIR_BITS  = 4;

    localparam logic [7:0] HOLD_MAX = 8'hFF;

    // Commands
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Event codes
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_CONFIRM  = 4'd1;
    localparam logic [3:0] EV_ESCAPE   = 4'd2;
    localparam logic [3:0] EV_HELP     = 4'd3;
    localparam logic [3:0] EV_UP       = 4'd4;
    localparam logic [3:0] EV_DOWN     = 4'd5;
    localparam logic [3:0] EV_LEFT     = 4'd6;
    localparam logic [3:0] EV_RIGHT    = 4'd7;
    localparam logic [3:0] EV_ROW      = 4'd8;
    localparam logic [3:0] EV_SHOW     = 4'd9;
    localparam logic [3:0] EV_INJECTED = 4'd10;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_IDLE_LEN      = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_REPEAT_DELAY       = 8'd12;
    localparam logic [2:0] RST_REPEAT_PERIOD_LOG2 = 3'd2;
    localparam logic [7:0] RST_SHOW_IDLE_LEN      = 8'd8;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pushed_key;
        logic [7:0] pressed;
        logic [7:0] held;
        logic       show_req;
        logic       row_req;
    } item_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] key_value;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           wdata;
    } cfg_word_t;

    typedef struct packed {
        logic [7:0] repeat_delay;
        logic [2:0] repeat_period_log2;
        logic [7:0] show_idle_len;
    } cfg_t;

    typedef struct packed {
        logic [DIR_BITS-1:0] repeat_dirs;
        logic [7:0]          hold_count;
        logic [7:0]          idle_count;
    } state_t;

endpackage

`default_nettype wire

// ===== sv/kaes_ifs.sv =====
`default_nettype none

interface kaes_item_if;
    import kaes_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kaes_result_if;
    import kaes_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kaes_cfg_if;
    import kaes_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/kaes_cfg_regs.sv =====
`default_nettype none

module kaes_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    kaes_cfg_if.sink      cfg,
    output kaes_pkg::cfg_t cfg_q
);
    import kaes_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_REPEAT_DELAY:       cfg_next.repeat_delay       = cfg.data.wdata;
                REG_REPEAT_PERIOD_LOG2: cfg_next.repeat_period_log2 = cfg.data.wdata[2:0];
                REG_SHOW_IDLE_LEN:      cfg_next.show_idle_len      = cfg.data.wdata;
                default:                cfg_next = cfg_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_delay       <= RST_REPEAT_DELAY;
            cfg_reg.repeat_period_log2 <= RST_REPEAT_PERIOD_LOG2;
            cfg_reg.show_idle_len      <= RST_SHOW_IDLE_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kaes_event_logic.sv =====
`default_nettype none

module kaes_event_logic (
    input  kaes_pkg::item_t   item_data,
    input  kaes_pkg::cfg_t    cfg_q,
    input  kaes_pkg::state_t  state_cur,
    output kaes_pkg::result_t res,
    output kaes_pkg::state_t  state_next
);
    import kaes_pkg::*;

    logic [DIR_BITS-1:0] held_dirs;
    logic [DIR_BITS-1:0] press_dirs;
    logic [7:0]          hold_upd;
    logic [7:0]          period_mask;
    logic [7:0]          idle_inc;
    logic                repeat_due;

    assign held_dirs   = item_data.held[DIR_BITS-1:0];
    assign press_dirs  = item_data.pressed[DIR_BITS-1:0];
    assign period_mask = (8'd1 << cfg_q.repeat_period_log2) - 8'd1;
    assign idle_inc    = state_cur.idle_count + 8'd1;

    // Hold count after this frame when a direction is down
    always_comb
    begin
        if (held_dirs != state_cur.repeat_dirs)
            hold_upd = 8'd0;
        else if (state_cur.hold_count != HOLD_MAX)
            hold_upd = state_cur.hold_count + 8'd1;
        else
            hold_upd = state_cur.hold_count;
    end

    assign repeat_due = (hold_upd >= cfg_q.repeat_delay) && ((hold_upd & period_mask) == 8'd0);

    always_comb
    begin
        logic [DIR_BITS-1:0] move;
        move       = '0;
        state_next = state_cur;
        res        = '{event_res: EV_NONE, key_value: 8'd0};

        if (item_data.cmd == CMD_CLEAR)
        begin
            state_next = '0;
        end
        else if (item_data.pushed_key != 8'd0)
        begin
            res.event_res = EV_INJECTED;
            res.key_value = item_data.pushed_key;
        end
        else if (item_data.pressed[BIT_A])
        begin
            state_next.idle_count = 8'd0;
            res.event_res         = EV_CONFIRM;
        end
        else if (item_data.pressed[BIT_B])
        begin
            state_next.idle_count = 8'd0;
            res.event_res         = EV_ESCAPE;
        end
        else if (item_data.pressed[BIT_START])
        begin
            state_next.idle_count = 8'd0;
            res.event_res         = EV_HELP;
        end
        else
        begin
            if (held_dirs != '0)
            begin
                state_next.repeat_dirs = held_dirs;
                state_next.hold_count  = hold_upd;
                state_next.idle_count  = 8'd0;
                if (press_dirs != '0)
                    move = press_dirs;
                else if (repeat_due)
                    move = held_dirs;
            end
            else
            begin
                state_next.repeat_dirs = '0;
                state_next.hold_count  = 8'd0;
                move                   = press_dirs;
            end

            if (move != '0)
            begin
                state_next.idle_count = 8'd0;
                if (move[BIT_UP])
                    res.event_res = EV_UP;
                else if (move[BIT_DOWN])
                    res.event_res = EV_DOWN;
                else if (move[BIT_LEFT])
                    res.event_res = EV_LEFT;
                else
                    res.event_res = EV_RIGHT;
            end
            else if (item_data.row_req)
            begin
                res.event_res = EV_ROW;
            end
            else if (item_data.show_req && (item_data.held == 8'd0))
            begin
                if (idle_inc >= cfg_q.show_idle_len)
                begin
                    state_next.idle_count = 8'd0;
                    res.event_res         = EV_SHOW;
                end
                else
                begin
                    state_next.idle_count = idle_inc;
                end
            end
            else if (!item_data.show_req)
            begin
                state_next.idle_count = 8'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/keypad_autorepeat_event_select.sv =====
// An accepted input word waits in the input register; its event then moves into the result register
// once that is free, and the result side takes it from there (input register, then result register).
// Throughput: one word per cycle, sustained while the result side takes a word each cycle.
// The result register frees as it drains, so a new input word is taken alongside a pending result.
// Reset: rst_n (async, active low) empties both stages, zeroes repeat/hold/idle state and
// loads repeat_delay 12, repeat_period_log2 2, show idle length 8.
`default_nettype none

module keypad_autorepeat_event_select (
    input  logic          clk,
    input  logic          rst_n,
    kaes_item_if.sink     item,
    kaes_result_if.source result,
    kaes_cfg_if.sink      cfg
);
    import kaes_pkg::*;

    // Input stage: holds one frame word until the result register can take its event
    logic    stage_valid_reg;
    logic    stage_valid_next;
    item_t   stage_item_reg;

    // Result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    // Repeat and idle tracking, updated as a word moves from input to result stage
    state_t  state_reg;
    state_t  state_next;
    state_t  state_calc;

    cfg_t    cfg_q;
    result_t res_calc;

    logic    out_free;
    logic    advance;
    logic    take_in;

    kaes_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    kaes_event_logic u_event_logic (
        .item_data  (stage_item_reg),
        .cfg_q      (cfg_q),
        .state_cur  (state_reg),
        .res        (res_calc),
        .state_next (state_calc)
    );

    // Result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || result.ready;
    // Advance the held frame word into the result register
    assign advance  = stage_valid_reg && out_free;
    // Input stage takes a word when empty or when its word advances
    assign item.ready = !stage_valid_reg || advance;
    assign take_in    = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_in)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;

        // Commit state only when the word's event is actually produced
        state_next = advance ? state_calc : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
            stage_item_reg <= item.data;
        if (advance)
            out_data_reg <= res_calc;
    end

`ifndef SYNTHESIS
    // A clear command leaves all tracking state at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_item_reg.cmd == CMD_CLEAR) |=> (state_reg == '0))
        else $error("state not cleared after clear command");

    // An injected key leaves tracking state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_item_reg.cmd == CMD_STEP && stage_item_reg.pushed_key != 8'd0)
        |=> $stable(state_reg))
        else $error("injected key changed state");

    // A nonzero hold count implies a held direction mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.hold_count != 8'd0) |-> (state_reg.repeat_dirs != '0))
        else $error("hold count running with no direction held");

    // Key value is carried exactly on injected events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((out_data_reg.event_res == EV_INJECTED) == (out_data_reg.key_value != 8'd0)))
        else $error("key value does not match event code");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import kaes_pkg::*;

    // Run length guards
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned RUN_CAP      = 300;

    logic clk;
    logic rst_n;

    kaes_item_if   frame_if ();
    kaes_result_if event_if ();
    kaes_cfg_if    reg_if ();

    keypad_autorepeat_event_select DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (frame_if),
        .result (event_if),
        .cfg    (reg_if)
    );

    // Predictor copy of the selector: register settings and key state
    cfg_t   reg_shadow;
    state_t key_state;

    // Events still owed by the block, oldest first
    result_t pending_events[$];

    // Idle shaping, in percent, and the receiver hold-off length in cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_left;

    int unsigned cycle_cnt;
    int unsigned frames_sent;
    int unsigned events_checked;
    int unsigned fail_cnt;
    int unsigned auto_repeats;
    int unsigned show_events;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still owed", cycle_cnt,
                     pending_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Count down the long receiver hold-off, one step per cycle
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
    end

    // Work out the event that one accepted frame word causes and advance the
    // predicted key state. The order is: clear, injected key, confirm, escape,
    // help, direction (fresh press or auto-repeat), row, show.
    function automatic result_t select_event(input item_t w);
        result_t             r;
        logic [DIR_BITS-1:0] dirs_held;
        logic [DIR_BITS-1:0] dirs_new;
        logic [DIR_BITS-1:0] move;
        logic [7:0]          period_mask;
        r         = '0;
        move      = '0;
        dirs_held = w.held[DIR_BITS-1:0];
        dirs_new  = w.pressed[DIR_BITS-1:0];

        // Clear drops all key state and ignores every other field
        if (w.cmd == CMD_CLEAR)
        begin
            key_state = '0;
            return r;
        end
        // Injected key wins over every field but a clear and leaves the state alone
        if (w.pushed_key != 8'd0)
        begin
            r.event_res = EV_INJECTED;
            r.key_value = w.pushed_key;
            return r;
        end
        if (w.pressed[BIT_A])
        begin
            key_state.idle_count = '0;
            r.event_res = EV_CONFIRM;
            return r;
        end
        if (w.pressed[BIT_B])
        begin
            key_state.idle_count = '0;
            r.event_res = EV_ESCAPE;
            return r;
        end
        if (w.pressed[BIT_START])
        begin
            key_state.idle_count = '0;
            r.event_res = EV_HELP;
            return r;
        end

        if (dirs_held != '0)
        begin
            // A new mask restarts the hold count; a steady one counts up and saturates
            if (dirs_held != key_state.repeat_dirs)
            begin
                key_state.repeat_dirs = dirs_held;
                key_state.hold_count  = '0;
            end
            else if (key_state.hold_count != HOLD_MAX)
                key_state.hold_count = key_state.hold_count + 8'd1;
            period_mask = (8'd1 << reg_shadow.repeat_period_log2) - 8'd1;
            if (dirs_new != '0)
                move = dirs_new;
            else if (key_state.hold_count >= reg_shadow.repeat_delay &&
                     (key_state.hold_count & period_mask) == 8'd0)
            begin
                move = dirs_held;
                auto_repeats++;
            end
            key_state.idle_count = '0;
        end
        else
        begin
            key_state.repeat_dirs = '0;
            key_state.hold_count  = '0;
            if (dirs_new != '0)
                move = dirs_new;
        end

        // Several directions at once: up, then down, then left, then right
        if (move != '0)
        begin
            key_state.idle_count = '0;
            if (move[BIT_UP])
                r.event_res = EV_UP;
            else if (move[BIT_DOWN])
                r.event_res = EV_DOWN;
            else if (move[BIT_LEFT])
                r.event_res = EV_LEFT;
            else
                r.event_res = EV_RIGHT;
            return r;
        end

        if (w.row_req)
        begin
            r.event_res = EV_ROW;
            return r;
        end

        // Any held button, the unused bit six included, keeps the frame from counting as idle
        if (w.show_req && w.held == 8'd0)
        begin
            key_state.idle_count = key_state.idle_count + 8'd1;
            if (key_state.idle_count >= reg_shadow.show_idle_len)
            begin
                key_state.idle_count = '0;
                r.event_res = EV_SHOW;
                show_events++;
            end
        end
        else if (!w.show_req)
            key_state.idle_count = '0;
        return r;
    endfunction

    // Take event words with random stalls and check each against the oldest
    // prediction
    initial
    begin
        result_t want;
        event_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (event_if.valid && event_if.ready)
            begin
                events_checked++;
                if (pending_events.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("stray event word: event %0d key %0h",
                                 event_if.data.event_res, event_if.data.key_value);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_if.data.event_res !== want.event_res ||
                        event_if.data.key_value !== want.key_value)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("event word %0d: expected event %0d key %0h, got event %0d key %0h",
                                     events_checked, want.event_res, want.key_value,
                                     event_if.data.event_res, event_if.data.key_value);
                    end
                end
            end
            // Hold ready low through a hold-off, else stall at the phase's rate
            event_if.ready <= (hold_off_left == 0) &&
                              ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic item_t mk_frame(input logic cmd, input logic [7:0] key,
                                       input logic [7:0] pressed, input logic [7:0] held,
                                       input logic show, input logic row);
        item_t w;
        w.cmd        = cmd;
        w.pushed_key = key;
        w.pressed    = pressed;
        w.held       = held;
        w.show_req   = show;
        w.row_req    = row;
        return w;
    endfunction

    // Offer one frame word after a random gap and log its prediction once taken
    task automatic send_frame(input item_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= w;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        pending_events.push_back(select_event(w));
        frames_sent++;
    endtask

    // Drop valid, wait out every owed event and the pipeline tail
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_word_t w;
        w.index = idx;
        w.wdata = value;
        reg_if.valid <= 1'b1;
        reg_if.data  <= w;
        @(posedge clk);
        while (!reg_if.ready)
            @(posedge clk);
        case (idx)
            REG_REPEAT_DELAY:       reg_shadow.repeat_delay       = value;
            REG_REPEAT_PERIOD_LOG2: reg_shadow.repeat_period_log2 = value[2:0];
            REG_SHOW_IDLE_LEN:      reg_shadow.show_idle_len      = value;
            default: ;
        endcase
    endtask

    // Write all three registers back to back; only call with the block idle
    task automatic load_settings(input logic [7:0] delay, input logic [2:0] period_log2,
                                 input logic [7:0] show_frames);
        write_reg(REG_REPEAT_DELAY, delay);
        write_reg(REG_REPEAT_PERIOD_LOG2, {5'd0, period_log2});
        write_reg(REG_SHOW_IDLE_LEN, show_frames);
        reg_if.valid <= 1'b0;
    endtask

    // Hold a direction mask steady for a random length that can reach auto-repeat, with
    // occasional mask changes, extra buttons and interrupting presses
    task automatic hold_run();
        logic [DIR_BITS-1:0] dirs;
        int unsigned         len;
        int unsigned         span;
        item_t               w;
        dirs = 4'($urandom_range(1, 15));
        span = reg_shadow.repeat_delay + (2 << reg_shadow.repeat_period_log2) + 4;
        if (span > RUN_CAP)
            span = RUN_CAP;
        len = $urandom_range(1, span);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                dirs = 4'($urandom_range(1, 15));
            w = mk_frame(CMD_STEP, 8'd0, 8'd0, {4'd0, dirs},
                         1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                w.held[7:4] = 4'($urandom_range(0, 15));
            if (k == 0 && $urandom_range(0, 3) != 0)
                w.pressed[DIR_BITS-1:0] = dirs;
            else if ($urandom_range(0, 29) == 0)
                w.pressed = 8'($urandom_range(0, 255));
            send_frame(w);
        end
    endtask

    // Leave the pad idle, mostly with a show pending, for a random length that can cross the threshold
    task automatic idle_run();
        int unsigned len;
        int unsigned span;
        item_t       w;
        span = reg_shadow.show_idle_len + 3;
        if (span > RUN_CAP)
            span = RUN_CAP;
        len = $urandom_range(1, span);
        for (int k = 0; k < len; k++)
        begin
            w = mk_frame(CMD_STEP, 8'd0, 8'd0, 8'd0,
                         $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
            if ($urandom_range(0, 24) == 0)
                w.held[6] = 1'b1;
            send_frame(w);
        end
    endtask

    function automatic item_t noise_frame();
        item_t w;
        w.cmd        = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_STEP;
        w.pushed_key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        case ($urandom_range(0, 2))
            0:       w.pressed = 8'd0;
            1:       w.pressed = 8'($urandom_range(0, 255));
            default: w.pressed = 8'($urandom_range(0, 255)) & 8'h4F;
        endcase
        w.held     = 8'($urandom_range(0, 255));
        w.show_req = 1'($urandom_range(0, 1));
        w.row_req  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Mostly well-formed hold and idle stretches, the rest random words
    task automatic run_traffic(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = frames_sent + count;
        while (frames_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                hold_run();
            else if (pick < 70)
                idle_run();
            else
                send_frame(noise_frame());
        end
        settle();
    endtask

    // Priorities and special cases at the reset settings
    task automatic test_directed_priorities();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(mk_frame(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_frame(mk_frame(CMD_STEP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_frame(mk_frame(CMD_STEP, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'hA0, 8'h00, 1'b0, 1'b0));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h80, 8'h00, 1'b0, 1'b0));
        // bit six alone: no event, and the pad is not idle
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h40, 8'h40, 1'b1, 1'b0));
        // several directions at once
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h0F, 8'h0F, 1'b0, 1'b1));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h0B, 8'h0B, 1'b0, 1'b0));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h03, 8'h00, 1'b0, 1'b0));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        send_frame(mk_frame(CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        // count idle frames up to the show threshold
        repeat (RST_SHOW_IDLE_LEN)
            send_frame(mk_frame(CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        settle();
    endtask

    task automatic test_traffic_reset_settings();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(250);
    endtask

    // Repeat on every held frame and show on every idle pending frame
    task automatic test_zero_settings_sender_idle();
        load_settings(8'd0, 3'd0, 8'd0);
        send_idle_pct  = 73;
        recv_stall_pct = 0;
        run_traffic(180);
    endtask

    task automatic test_short_settings_receiver_stall();
        load_settings(8'd3, 3'd1, 8'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        run_traffic(250);
    endtask

    // Longest delay and period: the hold count saturates and never meets the repeat condition
    task automatic test_max_settings();
        load_settings(8'hFF, 3'd7, 8'hFF);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_traffic(250);
    endtask

    // Hold the receiver off while frames keep coming, so the block backs up
    task automatic test_backpressure();
        load_settings(8'd5, 3'd3, 8'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left <= 150;
        run_traffic(60);
    endtask

    task automatic test_reset_values_reloaded();
        load_settings(RST_REPEAT_DELAY, RST_REPEAT_PERIOD_LOG2, RST_SHOW_IDLE_LEN);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_traffic(120);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        frame_if.valid = 1'b0;
        frame_if.data  = '0;
        reg_if.valid   = 1'b0;
        reg_if.data    = '0;
        hold_off_left  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_cnt      = 0;
        frames_sent    = 0;
        events_checked = 0;
        fail_cnt       = 0;
        auto_repeats   = 0;
        show_events    = 0;
        key_state      = '0;
        reg_shadow.repeat_delay       = RST_REPEAT_DELAY;
        reg_shadow.repeat_period_log2 = RST_REPEAT_PERIOD_LOG2;
        reg_shadow.show_idle_len      = RST_SHOW_IDLE_LEN;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_priorities();
        test_traffic_reset_settings();
        test_zero_settings_sender_idle();
        test_short_settings_receiver_stall();
        test_max_settings();
        test_backpressure();
        test_reset_values_reloaded();

        if (pending_events.size() != 0)
        begin
            fail_cnt++;
            $display("%0d events never arrived", pending_events.size());
        end
        $display("Sent %0d frame words and checked %0d event words in seven test phases",
                 frames_sent, events_checked);
        $display("Auto-repeat moves seen: %0d, show events seen: %0d, failures: %0d",
                 auto_repeats, show_events, fail_cnt);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== keypad_autorepeat_event_select.f =====
sv/kaes_pkg.sv
sv/kaes_ifs.sv
sv/kaes_cfg_regs.sv
sv/kaes_event_logic.sv
sv/keypad_autorepeat_event_select.sv
tb/sv/tb.sv
